/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the first expression holds, the second must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* src/fpcs_pkg.sv */
package fpcs_pkg;

  localparam logic [7:0] STX      = 8'h02;
  localparam logic [7:0] ETX      = 8'h03;
  localparam logic [7:0] ACK      = 8'h06;
  localparam logic [7:0] NAK      = 8'h15;
  localparam logic [7:0] OP_ON    = 8'h10;
  localparam logic [7:0] OP_OFF   = 8'h11;
  localparam logic [7:0] OP_SET   = 8'h12;
  localparam logic [7:0] OP_GET   = 8'h13;
  localparam logic [7:0] OP_PING  = 8'h20;
  localparam logic [7:0] OP_VER   = 8'h21;
  localparam logic [7:0] ALL_ON   = 8'hFF;
  localparam logic [7:0] CHAR_P   = 8'h50;
  localparam logic [7:0] CHAR_O   = 8'h4F;
  localparam logic [7:0] CHAR_N   = 8'h4E;
  localparam logic [7:0] CHAR_G   = 8'h47;

  localparam logic [7:0] MAX_LEN_RESET   = 8'd32;
  localparam logic [7:0] VER_MAJOR_RESET = 8'd1;
  localparam logic [7:0] VER_MINOR_RESET = 8'd0;

  localparam logic [7:0] CFG_MAX_LEN   = 8'd0;
  localparam logic [7:0] CFG_VER_MAJOR = 8'd1;
  localparam logic [7:0] CFG_VER_MINOR = 8'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CSUM,
    PH_ETX
  } phase_e;

  typedef enum logic [2:0] {
    RESP_ACK,
    RESP_NAK,
    RESP_GET,
    RESP_PING,
    RESP_VER
  } resp_kind_e;

  typedef struct packed {
    resp_kind_e  kind;
    logic [7:0]  led;
    logic [7:0]  arg0;
    logic [7:0]  arg1;
  } resp_desc_t;

  typedef logic [3:0] run_idx_t;

  // Number of bytes in the response run of one descriptor.
  function automatic run_idx_t resp_run_len(resp_kind_e kind);
    run_idx_t n;
    unique case (kind)
      RESP_GET:  n = 4'd6;
      RESP_PING: n = 4'd9;
      RESP_VER:  n = 4'd7;
      default:   n = 4'd1;
    endcase
    return n;
  endfunction

  // Byte at position idx of the response run of one descriptor.
  function automatic logic [7:0] resp_byte(resp_desc_t d, run_idx_t idx);
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] p3;
    logic [7:0] cs;
    logic [7:0] b;
    logic       pkt;
    run_idx_t   pidx;
    run_idx_t   len_n;
    cmd = '0;
    len = '0;
    p0  = '0;
    p1  = '0;
    p2  = '0;
    p3  = '0;
    pkt = 1'b1;
    b   = NAK;
    unique case (d.kind)
      RESP_ACK: begin
        pkt = 1'b0;
        b   = ACK;
      end
      RESP_GET: begin
        cmd = OP_GET;
        len = 8'd1;
        p0  = d.arg0;
      end
      RESP_PING: begin
        cmd = OP_PING;
        len = 8'd4;
        p0  = CHAR_P;
        p1  = CHAR_O;
        p2  = CHAR_N;
        p3  = CHAR_G;
      end
      RESP_VER: begin
        cmd = OP_VER;
        len = 8'd2;
        p0  = d.arg0;
        p1  = d.arg1;
      end
      default: begin
        pkt = 1'b0;
        b   = NAK;
      end
    endcase
    cs    = cmd ^ len ^ p0 ^ p1 ^ p2 ^ p3;
    pidx  = idx - 4'd3;
    len_n = len[3:0];
    if (pkt) begin
      if (idx == 4'd0) begin
        b = STX;
      end else if (idx == 4'd1) begin
        b = cmd;
      end else if (idx == 4'd2) begin
        b = len;
      end else if (pidx < len_n) begin
        unique case (pidx[1:0])
          2'd0: b = p0;
          2'd1: b = p1;
          2'd2: b = p2;
          default: b = p3;
        endcase
      end else if (pidx == len_n) begin
        b = cs;
      end else begin
        b = ETX;
      end
    end
    return b;
  endfunction

endpackage

/* src/fpcs_front.sv */
module fpcs_front
  import fpcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       q_push_o,
  output resp_desc_t q_desc_o,
  input  logic       q_full_i
);

  phase_e     phase_q, phase_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] first_q, first_d;
  logic [7:0] csum_q, csum_d;
  logic [7:0] led_q, led_d;
  logic [7:0] max_len_q;
  logic [7:0] ver_major_q;
  logic [7:0] ver_minor_q;
  logic [7:0] cnt_inc;
  logic       accept;
  logic       frame_ok;

  assign rx_stall_o  = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = rx_valid_i & ~q_full_i;
  assign cnt_inc     = cnt_q + 8'd1;
  assign frame_ok    = (rx_byte_i == ETX) && (xor_q == csum_q);

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_CMD: phase_d = PH_LEN;
        PH_LEN: begin
          if (rx_byte_i > max_len_q) begin
            phase_d = PH_HUNT;
          end else if (rx_byte_i == 8'd0) begin
            phase_d = PH_CSUM;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (cnt_inc >= len_q) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: phase_d = PH_ETX;
        PH_ETX:  phase_d = PH_HUNT;
        default: phase_d = (rx_byte_i == STX) ? PH_CMD : PH_HUNT;
      endcase
    end
  end

  always_comb begin
    cmd_d    = cmd_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    first_d  = first_q;
    csum_d   = csum_q;
    led_d    = led_q;
    q_push_o = 1'b0;
    q_desc_o = '{kind: RESP_NAK, led: led_q, arg0: led_q, arg1: '0};
    if (accept) begin
      unique case (phase_q)
        PH_CMD: begin
          cmd_d = rx_byte_i;
          xor_d = rx_byte_i;
        end
        PH_LEN: begin
          len_d = rx_byte_i;
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = '0;
          if (rx_byte_i > max_len_q) begin
            q_push_o = 1'b1;
          end
        end
        PH_DATA: begin
          if (cnt_q == 8'd0) begin
            first_d = rx_byte_i;
          end
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_inc;
        end
        PH_CSUM: csum_d = rx_byte_i;
        PH_ETX: begin
          q_push_o = 1'b1;
          if (frame_ok) begin
            unique case (cmd_q)
              OP_ON: begin
                led_d         = ALL_ON;
                q_desc_o.kind = RESP_ACK;
              end
              OP_OFF: begin
                led_d         = '0;
                q_desc_o.kind = RESP_ACK;
              end
              OP_SET: begin
                if (len_q == 8'd1) begin
                  led_d         = first_q;
                  q_desc_o.kind = RESP_ACK;
                end
              end
              OP_GET:  q_desc_o.kind = RESP_GET;
              OP_PING: q_desc_o.kind = RESP_PING;
              OP_VER: begin
                q_desc_o.kind = RESP_VER;
                q_desc_o.arg0 = ver_major_q;
                q_desc_o.arg1 = ver_minor_q;
              end
              default: q_desc_o.kind = RESP_NAK;
            endcase
          end
          q_desc_o.led = led_d;
          if (q_desc_o.kind == RESP_GET) begin
            q_desc_o.arg0 = led_d;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
      first_q <= '0;
      csum_q  <= '0;
      led_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      first_q <= first_d;
      csum_q  <= csum_d;
      led_q   <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RESET;
      ver_major_q <= VER_MAJOR_RESET;
      ver_minor_q <= VER_MINOR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_LEN:   max_len_q   <= cfg_data_i;
        CFG_VER_MAJOR: ver_major_q <= cfg_data_i;
        CFG_VER_MINOR: ver_minor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* src/fpcs_queue.sv */
module fpcs_queue
  import fpcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  resp_desc_t desc_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output resp_desc_t head_o
);

  resp_desc_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

/* src/fpcs_back.sv */
module fpcs_back
  import fpcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  resp_desc_t q_head_i,
  output logic       q_pop_o,
  output logic       tx_valid_o,
  input  logic       tx_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o,
  output logic [7:0] led_level_o
);

  resp_desc_t cur_q;
  logic       cur_valid_q, cur_valid_d;
  run_idx_t   idx_q, idx_d;
  logic       tx_valid_q, tx_valid_d;
  logic [7:0] tx_byte_q;
  logic       last_q;
  logic [7:0] led_q;
  logic       advance;
  logic       is_last;

  assign advance     = cur_valid_q && (!tx_valid_q || !tx_stall_i);
  assign is_last     = (idx_q == resp_run_len(cur_q.kind) - 4'd1);
  assign q_pop_o     = !q_empty_i && (!cur_valid_q || (advance && is_last));
  assign tx_valid_o  = tx_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;
  assign led_level_o = led_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    tx_valid_d  = tx_valid_q;
    if (q_pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (advance && is_last) begin
      cur_valid_d = 1'b0;
    end else if (advance) begin
      idx_d = idx_q + 4'd1;
    end
    if (advance) begin
      tx_valid_d = 1'b1;
    end else if (!tx_stall_i) begin
      tx_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      tx_valid_q  <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      tx_valid_q  <= tx_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
    if (advance) begin
      tx_byte_q <= resp_byte(cur_q, idx_q);
      last_q    <= is_last;
      led_q     <= cur_q.led;
    end
  end

endmodule

/* src/framed_packet_command_server_unit.sv */
// Framed packet command server. Received bytes enter one per cycle on the rx channel when
// not stalled; the front end parses STX, command, length, payload, checksum and ETX,
// updates the LED latch and queues one response descriptor per frame (or per rejected
// length). The back end turns each descriptor into a run of 1 to 9 bytes on the tx
// channel at one byte per cycle when not stalled, marking the final byte with
// last_byte_o. A two-entry response queue sits between the halves, so the receiver stalls
// only while it is full: when responses arrive faster than the back end drains them.
`include "assert_macros.svh"

module framed_packet_command_server_unit
  import fpcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       tx_valid_o,
  input  logic       tx_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o,
  output logic [7:0] led_level_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  resp_desc_t q_desc;
  resp_desc_t q_head;

  fpcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_push_o    (q_push),
    .q_desc_o    (q_desc),
    .q_full_i    (q_full)
  );

  fpcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  fpcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .tx_valid_o  (tx_valid_o),
    .tx_stall_i  (tx_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o),
    .led_level_o (led_level_o)
  );

  `ASSERT_ALWAYS(a_queue_no_overflow, !(q_push && q_full), "push into a full response queue")
  `ASSERT_ALWAYS(a_queue_no_underflow, !(q_pop && q_empty), "pop from an empty response queue")
  `ASSERT_ALWAYS(a_push_needs_beat, !(q_push && !(rx_valid_i && !rx_stall_o)), "push without rx beat")
  `ASSERT_NEXT(a_run_continuous, tx_valid_o && !tx_stall_i && !last_byte_o, tx_valid_o, "gap inside a response run")

endmodule

/* dv/framed_packet_command_server_unit_tb.sv */
`timescale 1ns / 100ps

module framed_packet_command_server_unit_tb
  import fpcs_pkg::*;
();

  localparam int SETTLE = 20;
  localparam int BYTES_PER_PHASE = 68;
  localparam int PHASES = 4;
  localparam logic [7:0] CFG_FIRST_UNUSED = CFG_VER_MINOR + 8'd1;

  typedef struct {
    logic [7:0] tx;
    logic       last;
    logic [7:0] led;
  } tx_beat_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    logic [7:0] tx;
    logic [7:0] led;
  } frame_row_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       tx_valid_o;
  logic       tx_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic       last_byte_o;
  logic [7:0] led_level_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  framed_packet_command_server_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .tx_valid_o (tx_valid_o),
    .tx_stall_i (tx_stall_i),
    .tx_byte_o  (tx_byte_o),
    .last_byte_o(last_byte_o),
    .led_level_o(led_level_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [7:0] cfg_max_len = MAX_LEN_RESET;
  logic [7:0] cfg_major = VER_MAJOR_RESET;
  logic [7:0] cfg_minor = VER_MINOR_RESET;

  phase_e     m_phase = PH_HUNT;
  logic [7:0] m_cmd = '0;
  logic [7:0] m_len = '0;
  logic [7:0] m_count = '0;
  logic [7:0] m_xor = '0;
  logic [7:0] m_first = '0;
  logic [7:0] m_csum = '0;
  logic [7:0] m_led = '0;
  bit         rx_ignored;

  logic [7:0] reply_run[$];
  tx_beat_t   tx_beats_due[$];
  int         fail_count = 0;
  int         fed;
  int         stall_left = 0;
  bit         calm = 1'b0;

  frame_row_t frame_rows[50] = '{
    '{8'h55, 1'b0, 8'h00, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_ON, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{OP_ON, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b1, ACK, ALL_ON},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_SET, 1'b0, 8'h00, 8'h00},
    '{8'h01, 1'b0, 8'h00, 8'h00},
    '{8'hA5, 1'b0, 8'h00, 8'h00},
    '{OP_SET ^ 8'h01 ^ 8'hA5, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b1, ACK, 8'hA5},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_GET, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{OP_GET, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b0, 8'h00, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_VER, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{OP_VER, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b0, 8'h00, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_PING, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{OP_PING, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b0, 8'h00, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_OFF, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{OP_OFF, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b1, ACK, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_ON, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b1, NAK, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{8'hFF, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b1, NAK, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_ON, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{8'h55, 1'b0, 8'h00, 8'h00},
    '{ETX, 1'b1, NAK, 8'h00},
    '{STX, 1'b0, 8'h00, 8'h00},
    '{OP_OFF, 1'b0, 8'h00, 8'h00},
    '{8'h00, 1'b0, 8'h00, 8'h00},
    '{OP_OFF, 1'b0, 8'h00, 8'h00},
    '{8'hFC, 1'b1, NAK, 8'h00}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic add_packet(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [31:0] body);
    logic [7:0] cs;
    cs = cmd ^ len;
    reply_run.push_back(STX);
    reply_run.push_back(cmd);
    reply_run.push_back(len);
    for (int i = 0; i < len; i++) begin
      reply_run.push_back(body[31 - 8 * i -: 8]);
      cs ^= body[31 - 8 * i -: 8];
    end
    reply_run.push_back(cs);
    reply_run.push_back(ETX);
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    reply_run = {};
    rx_ignored = 1'b0;
    case (m_phase)
      PH_CMD: begin
        m_cmd = b;
        m_xor = b;
        m_phase = PH_LEN;
      end
      PH_LEN: begin
        m_len = b;
        m_xor ^= b;
        m_count = '0;
        if (b > cfg_max_len) begin
          reply_run.push_back(NAK);
          m_phase = PH_HUNT;
        end else begin
          m_phase = (b == 8'h00) ? PH_CSUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (m_count == 8'h00) m_first = b;
        m_xor ^= b;
        m_count = m_count + 8'd1;
        if (m_count >= m_len) m_phase = PH_CSUM;
      end
      PH_CSUM: begin
        m_csum = b;
        m_phase = PH_ETX;
      end
      PH_ETX: begin
        m_phase = PH_HUNT;
        if (b != ETX || m_xor != m_csum) begin
          reply_run.push_back(NAK);
        end else begin
          case (m_cmd)
            OP_ON: begin
              m_led = ALL_ON;
              reply_run.push_back(ACK);
            end
            OP_OFF: begin
              m_led = '0;
              reply_run.push_back(ACK);
            end
            OP_SET: begin
              if (m_len == 8'd1) begin
                m_led = m_first;
                reply_run.push_back(ACK);
              end else begin
                reply_run.push_back(NAK);
              end
            end
            OP_GET: add_packet(OP_GET, 8'd1, {m_led, 24'h0});
            OP_PING: add_packet(OP_PING, 8'd4, {CHAR_P, CHAR_O, CHAR_N, CHAR_G});
            OP_VER: add_packet(OP_VER, 8'd2, {cfg_major, cfg_minor, 16'h0});
            default: reply_run.push_back(NAK);
          endcase
        end
      end
      default: begin
        rx_ignored = (b != STX);
        m_phase = (b == STX) ? PH_CMD : PH_HUNT;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [7:0] want_tx,
                           input logic [7:0] want_led);
    if (!calm && $urandom_range(0, 7) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    parse_rx_byte(b);
    if (!rx_ignored) fed++;
    if (typed) begin
      tx_beats_due.push_back('{want_tx, 1'b1, want_led});
    end else begin
      foreach (reply_run[i]) begin
        tx_beats_due.push_back('{reply_run[i], i == reply_run.size() - 1, m_led});
      end
    end
  endtask

  task automatic send_frame();
    logic [7:0] seq[$];
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] cs;
    logic [7:0] b;
    int         kind;
    int         n;
    seq = {};
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      case ($urandom_range(0, 7))
        0: cmd = OP_ON;
        1: cmd = OP_OFF;
        2, 3: cmd = OP_SET;
        4: cmd = OP_GET;
        5: cmd = OP_PING;
        6: cmd = OP_VER;
        default: cmd = 8'($urandom);
      endcase
      n = $urandom_range(0, 99);
      if (n < 8 && cfg_max_len < 8'hFF) begin
        len = 8'($urandom_range(cfg_max_len + 1, 255));
      end else if (n < 11) begin
        len = 8'($urandom_range(0, cfg_max_len));
      end else if (cmd == OP_SET && n < 80) begin
        len = 8'd1;
      end else begin
        len = 8'($urandom_range(0, (cfg_max_len < 8'd6) ? cfg_max_len : 6));
      end
      seq.push_back(STX);
      seq.push_back(cmd);
      seq.push_back(len);
      cs = cmd ^ len;
      if (len <= cfg_max_len) begin
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          seq.push_back(b);
          cs ^= b;
        end
        if ($urandom_range(0, 9) == 0) cs ^= 8'(1 << $urandom_range(0, 7));
        seq.push_back(cs);
        seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : ETX);
      end
    end else if (kind < 88) begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
    end else begin
      seq.push_back(STX);
      seq.push_back(8'($urandom));
      len = 8'($urandom_range(0, (cfg_max_len < 8'd6) ? cfg_max_len : 6));
      seq.push_back(len);
      repeat ($urandom_range(0, len)) seq.push_back(8'($urandom));
    end
    foreach (seq[i]) send_byte(seq[i], 1'b0, '0, '0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_MAX_LEN) cfg_max_len = val;
    else if (idx == CFG_VER_MAJOR) cfg_major = val;
    else if (idx == CFG_VER_MINOR) cfg_minor = val;
  endtask

  task automatic program_regs(input logic [7:0] max_len, input logic [7:0] major,
                              input logic [7:0] minor);
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_VER_MAJOR, major);
    write_reg(CFG_VER_MINOR, minor);
    write_reg(8'($urandom_range(CFG_FIRST_UNUSED, 255)), 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tx_beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    tx_beat_t want;
    if (rst_ni) begin
      if (tx_valid_o && !tx_stall_i) begin
        if (tx_beats_due.size() == 0) begin
          $error("tx_byte: expected nothing, got %02h", tx_byte_o);
          fail_count++;
        end else begin
          want = tx_beats_due.pop_front();
          if (tx_byte_o !== want.tx) begin
            $error("tx_byte: expected %02h, got %02h", want.tx, tx_byte_o);
            fail_count++;
          end
          if (last_byte_o !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, last_byte_o);
            fail_count++;
          end
          if (led_level_o !== want.led) begin
            $error("led_level: expected %02h, got %02h", want.led, led_level_o);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 5);
      tx_stall_i <= (stall_left > 0);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (frame_rows[i]) begin
      send_byte(frame_rows[i].rx, frame_rows[i].typed, frame_rows[i].tx, frame_rows[i].led);
    end
    for (int p = 0; p < PHASES; p++) begin
      rx_valid_i <= 1'b0;
      wait_idle();
      calm = (p == PHASES - 1);
      case (p)
        0: program_regs(8'hFF, 8'hFF, 8'hFF);
        1: program_regs(8'h00, 8'h00, 8'h00);
        2: program_regs(8'($urandom_range(1, 40)), 8'($urandom), 8'($urandom));
        default: program_regs(MAX_LEN_RESET, VER_MAJOR_RESET, VER_MINOR_RESET);
      endcase
      fed = 0;
      while (fed < BYTES_PER_PHASE) send_frame();
    end
    rx_valid_i <= 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/fpcs_pkg.sv
src/fpcs_front.sv
src/fpcs_queue.sv
src/fpcs_back.sv
src/framed_packet_command_server_unit.sv
dv/framed_packet_command_server_unit_tb.sv
